// File: hw/rtl/lzfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lzfd_pkg
// Shared constants, status codes and the packer control structs of the
// flag-bit LZ77 decompressor.
// ============================================================================
package lzfd_pkg;

  // History window: 64 KiB, addressed by the low bits of the output position
  localparam int HIST_AW        = 16;
  localparam int WINDOW_DEPTH   = 1 << HIST_AW;

  // Output packing: eight byte lanes per transaction
  localparam int OUT_LANES      = 8;
  localparam int OUT_W          = 8 * OUT_LANES;
  localparam int OUT_CNT_W      = 4;
  localparam int LANE_IDX_W     = 3;

  // Stream format
  localparam int CTRL_WORD_BITS = 32;
  localparam int MIN_MATCH      = 3;
  localparam int COPY_CNT_W     = 9;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DIST  = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_EARLY_END = 3'd3,
    ST_INPUT_OUT = 3'd4
  } status_t;

  // Request from the sequencer to the output packer
  typedef struct packed {
    logic        push;    // append one byte
    logic [7:0]  data;
    logic        flush;   // send the pack (with the pushed byte) as a result
    logic        last;
    status_t     status;
  } pack_cmd_t;

  // Packer condition seen by the sequencer
  typedef struct packed {
    logic room;       // a push is taken this cycle
    logic flush_ok;   // output register is free at the next edge
  } pack_stat_t;

endpackage

// File: hw/rtl/lzfd_hist_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lzfd_hist_ram
// 64 KiB history memory: one write port, one registered read port with
// write-to-read forwarding when both hit the same entry in one cycle.
// ============================================================================
module lzfd_hist_ram
  import lzfd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [HIST_AW-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [HIST_AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [WINDOW_DEPTH];

  // Write the produced byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry; forward the byte written in the same cycle; hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// File: hw/rtl/lzfd_packer.sv
`timescale 1ns / 1ps
// ============================================================================
// lzfd_packer
// Collects produced bytes into eight lanes and hands them to the output
// register, which holds a result until the downstream side takes it.
// ============================================================================
module lzfd_packer
  import lzfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  pack_cmd_t            cmd,
  output pack_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_bytes,
  output logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_last,
  output logic [2:0]           status
);

  logic [OUT_W-1:0]     pack_data;
  logic [OUT_CNT_W-1:0] pack_cnt;

  logic                 full;
  logic [OUT_W-1:0]     app_data;
  logic [OUT_CNT_W-1:0] app_cnt;
  logic                 load;
  logic [OUT_W-1:0]     load_bytes;
  logic [OUT_CNT_W-1:0] load_count;
  logic                 load_last;
  status_t              load_status;

  assign full           = (pack_cnt == OUT_CNT_W'(OUT_LANES));
  assign stat.flush_ok  = !out_valid || !out_stall;
  assign stat.room      = !full || stat.flush_ok;

  // Append the byte at the next free lane
  assign app_data = pack_data
                  | (OUT_W'(cmd.data) << {pack_cnt[LANE_IDX_W-1:0], 3'b000});
  assign app_cnt  = pack_cnt + OUT_CNT_W'(1);

  // Select what goes to the output register
  always_comb begin
    load        = 1'b0;
    load_bytes  = pack_data;
    load_count  = pack_cnt;
    load_last   = 1'b0;
    load_status = ST_OK;
    if (cmd.flush) begin
      load        = 1'b1;
      load_bytes  = cmd.push ? app_data : pack_data;
      load_count  = cmd.push ? app_cnt : pack_cnt;
      load_last   = cmd.last;
      load_status = cmd.status;
    end else if (cmd.push && full) begin
      load = 1'b1;
    end
  end

  // Control: output valid and pack fill
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pack_cnt  <= '0;
      pack_data <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pack_data <= '0;
        pack_cnt  <= '0;
      end else if (cmd.push) begin
        if (full) begin
          pack_data <= OUT_W'(cmd.data);
          pack_cnt  <= OUT_CNT_W'(1);
        end else begin
          pack_data <= app_data;
          pack_cnt  <= app_cnt;
        end
      end
    end
  end

  // Payload: load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_bytes <= load_bytes;
      out_count <= load_count;
      out_last  <= load_last;
      status    <= load_status;
    end
  end

endmodule

// File: hw/rtl/lz77_flagbit_decompressor.sv
`timescale 1ns / 1ps
// ============================================================================
// lz77_flagbit_decompressor
// LZ77 decompressor with MSB-first flag bits from 32-bit control words and
// 16-bit distances; history kept in a 64 KiB synchronous memory.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -----------------------------------
//  in       sink       in_valid / in_stall  in_byte[7:0], in_last
//  out      source     out_valid/out_stall  out_bytes[63:0], out_count[3:0],
//                                           out_last, status[2:0]
//  cfg      sink       cfg_we               cfg_data[31:0] -> raw_size
//
//  Control, literal, distance and terminator bytes are accepted while the
//  output register is free. A match's count byte starts the first history
//  read; the copy moves count+3 bytes, one read and one write per byte, and
//  S_FLUSH sends the final partial result. Reset is synchronous and active
//  high; the history memory is not cleared. A stall on the output holds the
//  copy loop whenever the pack is full and the output register is occupied.
//
module lz77_flagbit_decompressor
  import lzfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_bytes,
  output logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_last,
  output logic [2:0]           status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_FLUSH,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_CTRL = 3'd0,
    PH_LIT  = 3'd1,
    PH_DHI  = 3'd2,
    PH_DLO  = 3'd3,
    PH_CNT  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CTRL_WORD_BITS-1:0] cw;
    logic [5:0]                bits;
    phase_t                    phase;
    logic                      wbi_zero;
  } adv_t;

  // Take the next flag bit, or ask for a new control word
  function automatic adv_t advance(input logic [CTRL_WORD_BITS-1:0] cw,
                                   input logic [5:0] bits);
    adv_t a;
    a.cw       = cw;
    a.bits     = bits;
    a.phase    = PH_CTRL;
    a.wbi_zero = 1'b0;
    if (bits == 6'd0) begin
      a.wbi_zero = 1'b1;
    end else begin
      a.cw    = {cw[CTRL_WORD_BITS-2:0], 1'b0};
      a.bits  = bits - 6'd1;
      a.phase = cw[CTRL_WORD_BITS-1] ? PH_DHI : PH_LIT;
    end
    return a;
  endfunction

  // Registers
  state_t                    state, state_next;
  phase_t                    phase, phase_next;
  logic [CTRL_WORD_BITS-1:0] control_word, control_word_next;
  logic [5:0]                bits_left, bits_left_next;
  logic [1:0]                word_byte_index, word_byte_index_next;
  logic [15:0]               distance_hold, distance_hold_next;
  logic [31:0]               out_position, out_position_next;
  logic [31:0]               raw_size;
  logic [COPY_CNT_W-1:0]     copy_left, copy_left_next;
  logic [HIST_AW-1:0]        rd_ptr, rd_ptr_next;
  logic                      copy_last, copy_last_next;

  // Memory and packer connections
  logic                      ram_we;
  logic [HIST_AW-1:0]        ram_waddr;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [HIST_AW-1:0]        ram_raddr;
  logic [7:0]                ram_rdata;
  pack_cmd_t                 pcmd;
  pack_stat_t                pstat;

  logic                      accept;

  lzfd_hist_ram u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lzfd_packer u_pack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pcmd),
    .stat      (pstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last),
    .status    (status)
  );

  // Sequencer: parse one byte per transaction, copy one byte per cycle while the packer has room
  always_comb begin
    adv_t                      adv;
    logic                      do_adv;
    logic [CTRL_WORD_BITS-1:0] adv_cw;
    logic [5:0]                adv_bits;
    logic                      fin;
    logic                      emit;
    logic                      start;
    status_t                   st;
    logic [15:0]               dh_full;
    logic [31:0]               back_dist;
    logic [32:0]               end_pos;

    state_next           = state;
    phase_next           = phase;
    control_word_next    = control_word;
    bits_left_next       = bits_left;
    word_byte_index_next = word_byte_index;
    distance_hold_next   = distance_hold;
    out_position_next    = out_position;
    copy_left_next       = copy_left;
    rd_ptr_next          = rd_ptr;
    copy_last_next       = copy_last;

    ram_we    = 1'b0;
    ram_waddr = out_position[HIST_AW-1:0];
    ram_wdata = in_byte;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr;

    pcmd        = '0;
    pcmd.status = ST_OK;

    in_stall = 1'b1;
    accept   = 1'b0;

    do_adv    = 1'b0;
    adv_cw    = control_word;
    adv_bits  = bits_left;
    fin       = 1'b0;
    emit      = 1'b0;
    start     = 1'b0;
    st        = ST_OK;
    dh_full   = {distance_hold[15:8], in_byte};
    back_dist = 32'(17'h10000 - {1'b0, distance_hold});
    end_pos   = {1'b0, out_position} + 33'(in_byte) + 33'(MIN_MATCH);
    adv       = advance(adv_cw, adv_bits);

    case (state)
      S_IDLE: begin
        in_stall = !pstat.flush_ok;
        accept   = in_valid && pstat.flush_ok;
        if (accept) begin
          if (out_position >= raw_size) begin
            // Output already complete: drop the byte, close the stream
            fin = 1'b1;
            st  = (out_position > raw_size) ? ST_OVERRUN : ST_OK;
          end else begin
            case (phase)
              PH_CTRL: begin
                control_word_next    = {control_word[CTRL_WORD_BITS-9:0], in_byte};
                word_byte_index_next = word_byte_index + 2'd1;
                if (word_byte_index == 2'd3) begin
                  do_adv   = 1'b1;
                  adv_cw   = {control_word[CTRL_WORD_BITS-9:0], in_byte};
                  adv_bits = 6'(CTRL_WORD_BITS);
                end
              end
              PH_LIT: begin
                ram_we            = 1'b1;
                out_position_next = out_position + 32'd1;
                pcmd.push         = 1'b1;
                pcmd.data         = in_byte;
                emit              = 1'b1;
                if (out_position + 32'd1 == raw_size) begin
                  fin = 1'b1;
                end else begin
                  do_adv = 1'b1;
                end
              end
              PH_DHI: begin
                distance_hold_next = {in_byte, 8'h00};
                phase_next         = PH_DLO;
              end
              PH_DLO: begin
                distance_hold_next = dh_full;
                if (dh_full == 16'd0) begin
                  fin = 1'b1;
                  st  = ST_EARLY_END;
                end else begin
                  phase_next = PH_CNT;
                end
              end
              default: begin
                // Match: check distance, then room, then start the copy
                if (back_dist > out_position) begin
                  fin = 1'b1;
                  st  = ST_BAD_DIST;
                end else if (end_pos > {1'b0, raw_size}) begin
                  fin = 1'b1;
                  st  = ST_OVERRUN;
                end else begin
                  start          = 1'b1;
                  ram_re         = 1'b1;
                  ram_raddr      = out_position[HIST_AW-1:0] + distance_hold;
                  rd_ptr_next    = out_position[HIST_AW-1:0] + distance_hold
                                 + HIST_AW'(1);
                  copy_left_next = COPY_CNT_W'(in_byte) + COPY_CNT_W'(MIN_MATCH - 1);
                  copy_last_next = in_last;
                end
              end
            endcase
          end
          if (!fin && !start && in_last) begin
            fin = 1'b1;
            st  = ST_INPUT_OUT;
          end
          if (fin || emit) begin
            pcmd.flush  = 1'b1;
            pcmd.last   = fin;
            pcmd.status = st;
          end
          if (start) begin
            state_next = S_COPY;
          end else if (fin) begin
            state_next = S_DONE;
          end
        end
      end

      S_COPY: begin
        // Retire the byte held on the read port and issue the next read while the packer has room
        if (pstat.room) begin
          ram_we            = 1'b1;
          ram_wdata         = ram_rdata;
          out_position_next = out_position + 32'd1;
          pcmd.push         = 1'b1;
          pcmd.data         = ram_rdata;
          if (copy_left != '0) begin
            ram_re         = 1'b1;
            rd_ptr_next    = rd_ptr + HIST_AW'(1);
            copy_left_next = copy_left - COPY_CNT_W'(1);
          end else begin
            state_next = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        // Send the tail of the match and pick the next phase
        fin = (out_position == raw_size) || copy_last;
        st  = (out_position == raw_size || !copy_last) ? ST_OK : ST_INPUT_OUT;
        if (pstat.flush_ok) begin
          pcmd.flush  = 1'b1;
          pcmd.last   = fin;
          pcmd.status = st;
          do_adv      = 1'b1;
          state_next  = fin ? S_DONE : S_IDLE;
        end
      end

      default: begin
        // Finished: take and drop every byte
        in_stall = 1'b0;
        accept   = in_valid;
      end
    endcase

    if (do_adv) begin
      adv               = advance(adv_cw, adv_bits);
      control_word_next = adv.cw;
      bits_left_next    = adv.bits;
      phase_next        = adv.phase;
      if (adv.wbi_zero) begin
        word_byte_index_next = 2'd0;
      end
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_CTRL;
      control_word    <= '0;
      bits_left       <= '0;
      word_byte_index <= '0;
      distance_hold   <= '0;
      out_position    <= '0;
      raw_size        <= '0;
      copy_left       <= '0;
      rd_ptr          <= '0;
      copy_last       <= 1'b0;
    end else begin
      state           <= state_next;
      phase           <= phase_next;
      control_word    <= control_word_next;
      bits_left       <= bits_left_next;
      word_byte_index <= word_byte_index_next;
      distance_hold   <= distance_hold_next;
      out_position    <= out_position_next;
      copy_left       <= copy_left_next;
      rd_ptr          <= rd_ptr_next;
      copy_last       <= copy_last_next;
      if (cfg_we) begin
        raw_size <= cfg_data;
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for lz77_flagbit_decompressor. A byte-level tracker of
// the flag-bit LZ77 format predicts every packed output transaction and
// compares each one field by field. The byte stream is built from the
// tracker's parse state, so matches and distances stay well formed. After an
// opening directed sequence comes random traffic with input and output
// stalls and a long output hold-off. The run ends in one randomly chosen
// way: exact completion, bad distance, overrun by a copy, raw size
// rewritten, early terminator or input running out.
// ============================================================================
module testbench;
  import lzfd_pkg::*;

  localparam int unsigned SETTLE     = 32;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned CYCLE_CAP  = 2000000;
  localparam int unsigned MAX_DIST   = WINDOW_DEPTH - 1;

  // Parse position inside the packed stream
  typedef enum logic [2:0] {
    P_CTRL_WORD,
    P_LITERAL,
    P_DIST_HI,
    P_DIST_LO,
    P_COUNT
  } parse_phase_t;

  // How the stream is brought to its end
  typedef enum logic [2:0] {
    END_COMPLETE,
    END_BAD_DIST,
    END_OVERRUN_COPY,
    END_RESIZE,
    END_EARLY_TERM,
    END_INPUT_OUT
  } ending_t;

  // One output transaction
  typedef struct {
    logic [OUT_W-1:0]     bytes;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
    status_t              st;
  } decoded_pack_t;

  // --------------------------------------------------------------------------
  // Decoder tracker: follows the stream byte by byte and queues the packs
  // --------------------------------------------------------------------------
  class lz_unpack_tracker;
    logic [7:0]    hist [WINDOW_DEPTH];
    logic [31:0]   ctrl_word;
    int unsigned   bits_left;
    logic [1:0]    word_idx;
    parse_phase_t  phase;
    logic [15:0]   dist_field;
    logic [31:0]   out_pos;
    logic [31:0]   raw_size;
    bit            done;
    logic [7:0]    step_bytes [$];
    decoded_pack_t due_packs [$];
    int unsigned   mismatches;

    function new();
      ctrl_word  = '0;
      bits_left  = 0;
      word_idx   = '0;
      phase      = P_CTRL_WORD;
      dist_field = '0;
      out_pos    = '0;
      raw_size   = '0;
      done       = 1'b0;
      mismatches = 0;
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      // keep the log short when the block is badly off
      if (mismatches < 100)
        $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
      mismatches++;
    endfunction

    function void put(logic [7:0] b);
      hist[out_pos[15:0]] = b;
      out_pos = out_pos + 32'd1;
      step_bytes.push_back(b);
    endfunction

    // Select the next parse phase; return 1 when the output is complete
    function bit next_token();
      if (out_pos == raw_size) return 1'b1;
      if (bits_left == 0) begin
        phase    = P_CTRL_WORD;
        word_idx = 2'd0;
      end else begin
        phase     = ctrl_word[31] ? P_DIST_HI : P_LITERAL;
        ctrl_word = ctrl_word << 1;
        bits_left--;
      end
      return 1'b0;
    endfunction

    // Note one accepted input transaction and queue what it produces
    function void take_byte(logic [7:0] b, logic lst);
      bit            fin;
      status_t       st;
      int unsigned   back_dist;
      int unsigned   cnt;
      int unsigned   n;
      int unsigned   packs;
      int unsigned   k;
      int unsigned   r;
      decoded_pack_t p;
      if (done) return;
      fin = 1'b0;
      st  = ST_OK;
      step_bytes.delete();
      if (out_pos >= raw_size) begin
        // output already complete: drop the byte and close
        fin = 1'b1;
        st  = (out_pos > raw_size) ? ST_OVERRUN : ST_OK;
      end else begin
        case (phase)
          P_CTRL_WORD: begin
            ctrl_word = {ctrl_word[23:0], b};
            word_idx  = word_idx + 2'd1;
            if (word_idx == 2'd0) begin
              bits_left = CTRL_WORD_BITS;
              fin = next_token();
            end
          end
          P_LITERAL: begin
            put(b);
            fin = next_token();
          end
          P_DIST_HI: begin
            dist_field = {b, 8'h00};
            phase = P_DIST_LO;
          end
          P_DIST_LO: begin
            dist_field[7:0] = b;
            if (dist_field == 16'd0) begin
              fin = 1'b1;
              st  = ST_EARLY_END;
            end else begin
              phase = P_COUNT;
            end
          end
          default: begin
            back_dist = WINDOW_DEPTH - dist_field;
            cnt       = b + MIN_MATCH;
            if (back_dist > out_pos) begin
              fin = 1'b1;
              st  = ST_BAD_DIST;
            end else if (64'(out_pos) + 64'(cnt) > 64'(raw_size)) begin
              fin = 1'b1;
              st  = ST_OVERRUN;
            end else begin
              for (k = 0; k < cnt; k++) put(hist[16'(out_pos - back_dist)]);
              fin = next_token();
            end
          end
        endcase
      end
      if (!fin && lst) begin
        fin = 1'b1;
        st  = ST_INPUT_OUT;
      end
      if (fin) done = 1'b1;

      // Pack eight bytes per transaction, unused lanes zero
      n     = step_bytes.size();
      packs = (n + OUT_LANES - 1) / OUT_LANES;
      if (fin && packs == 0) packs = 1;
      for (r = 0; r < packs; r++) begin
        p.bytes = '0;
        p.count = '0;
        for (k = 0; k < OUT_LANES; k++) begin
          if (r * OUT_LANES + k < n) begin
            p.bytes[8*k +: 8] = step_bytes[r * OUT_LANES + k];
            p.count = p.count + 1'b1;
          end
        end
        p.last = fin && (r + 1 == packs);
        p.st   = p.last ? st : ST_OK;
        due_packs.push_back(p);
      end
    endfunction

    // Compare one accepted output transaction with the oldest pack due
    function void check_pack(logic [OUT_W-1:0] bytes, logic [OUT_CNT_W-1:0] cnt,
                             logic lst, logic [2:0] st);
      decoded_pack_t want;
      if (due_packs.size() == 0) begin
        report("unexpected transaction, out_bytes", bytes, 64'd0);
        return;
      end
      want = due_packs.pop_front();
      if (bytes !== want.bytes) report("out_bytes", bytes, want.bytes);
      if (cnt !== want.count) report("out_count", 64'(cnt), 64'(want.count));
      if (lst !== want.last) report("out_last", 64'(lst), 64'(want.last));
      if (st !== want.st) report("status", 64'(st), 64'(want.st));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_bytes;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_last;
  logic [2:0]           status;

  lz77_flagbit_decompressor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last),
    .status    (status)
  );

  lz_unpack_tracker unpack;

  // Stimulus knobs
  bit          idle_on   = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned match_pct = 30;
  logic [15:0] dist_gen  = '0;
  int unsigned hold_left  = 0;
  int unsigned burst_left = 0;
  int unsigned cycles     = 0;

  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: check accepted transactions, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      unpack.check_pack(out_bytes, out_count, out_last, status);
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stream generation and driving
  // --------------------------------------------------------------------------

  // Choose a byte that fits the current parse position
  function automatic logic [7:0] pick_byte();
    logic [7:0]  v;
    int unsigned reach;
    int unsigned back_dist;
    int unsigned roll;
    v = '0;
    case (unpack.phase)
      P_CTRL_WORD:
        for (int i = 0; i < 8; i++) v[i] = ($urandom_range(0, 99) < match_pct);
      P_LITERAL:
        v = 8'($urandom_range(0, 255));
      P_DIST_HI: begin
        reach = (unpack.out_pos > MAX_DIST) ? MAX_DIST : unpack.out_pos;
        if (reach == 0) reach = 1;
        if ($urandom_range(0, 7) == 0)
          back_dist = $urandom_range(1, reach);
        else
          back_dist = $urandom_range(1, (reach < 24) ? reach : 24);
        dist_gen = 16'(WINDOW_DEPTH - back_dist);
        v = dist_gen[15:8];
      end
      P_DIST_LO:
        v = dist_gen[7:0];
      default: begin
        roll = $urandom_range(0, 9);
        if (roll == 0) v = 8'hFF;
        else if (roll == 1) v = 8'($urandom_range(0, 255));
        else v = 8'($urandom_range(0, 12));
      end
    endcase
    return v;
  endfunction

  // Offer one input transaction and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    do @(posedge clk); while (in_stall);
    unpack.take_byte(b, lst);
  endtask

  // Advance through the stream until the parser reaches a phase
  task automatic run_to(input parse_phase_t target);
    int unsigned guard;
    guard = 0;
    while (unpack.phase != target && !unpack.done && guard < 2000) begin
      send_byte(pick_byte(), 1'b0);
      guard++;
    end
  endtask

  // Stop sending and wait until every due pack has arrived
  task automatic drain(input int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (unpack.due_packs.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_raw_size(input logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    unpack.raw_size = v;
    @(posedge clk);
  endtask

  // Opening sequence: control bytes 0x32 0xFF 0x00 0x80, literals 0x00 and
  // 0xFF, a minimum copy at distance 1, a maximum copy at distance 2, two
  // literals, a copy reaching back to the first byte, and one more literal
  localparam logic [7:0] OPENING [18] = '{
    8'h32, 8'hFF, 8'h00, 8'h80,
    8'h00, 8'hFF,
    8'hFF, 8'hFF, 8'h00,
    8'hFF, 8'hFE, 8'hFF,
    8'hA5, 8'h5A,
    8'hFE, 8'hF7, 8'h07,
    8'h3C
  };

  initial begin
    ending_t     ending;
    logic [7:0]  c;
    int unsigned guard;
    unpack = new();
    ending = ending_t'($urandom_range(0, 5));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Both raw size extremes, the larger one kept
    write_raw_size(32'd0);
    write_raw_size(32'hFFFF_FFFF);

    // Directed opening
    idle_on = 1'b1;
    foreach (OPENING[i]) send_byte(OPENING[i], 1'b0);

    // Random traffic with a long output hold-off and a mid-run resize
    for (int i = 0; i < 70; i++) begin
      if (i == 20) hold_req = 1'b1;
      if (i == 60) begin
        drain(CYCLE_CAP);
        write_raw_size(32'h8000_0000 + $urandom_range(0, 32'h7FFF_0000));
      end
      send_byte(pick_byte(), 1'b0);
    end

    // Last part runs without idling
    idle_on = 1'b0;
    repeat (30) send_byte(pick_byte(), 1'b0);

    // Close the stream
    case (ending)
      END_COMPLETE: begin
        drain(CYCLE_CAP);
        write_raw_size(unpack.out_pos + $urandom_range(1, 40));
        guard = 0;
        while (!unpack.done && guard < 2000) begin
          send_byte(pick_byte(), 1'b0);
          guard++;
        end
      end
      END_BAD_DIST: begin
        run_to(P_DIST_HI);
        dist_gen = 16'(WINDOW_DEPTH - (unpack.out_pos + 1));
        send_byte(dist_gen[15:8], 1'b0);
        send_byte(dist_gen[7:0], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_OVERRUN_COPY: begin
        run_to(P_COUNT);
        drain(CYCLE_CAP);
        c = 8'($urandom_range(0, 255));
        write_raw_size(unpack.out_pos + c + MIN_MATCH - 1);
        send_byte(c, 1'b1);
      end
      END_RESIZE: begin
        drain(CYCLE_CAP);
        write_raw_size($urandom_range(0, 1) ? unpack.out_pos : 32'd0);
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      END_EARLY_TERM: begin
        run_to(P_DIST_HI);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
      end
      default: send_byte(pick_byte(), 1'b1);
    endcase

    // Bytes after the end are dropped
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (2) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain(20000);
    if (unpack.due_packs.size() != 0)
      unpack.report("packs never sent, count", 64'(unpack.due_packs.size()), 64'd0);
    if (unpack.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
